[rtl/rqvs_pkg.sv]
// shared types, widths, constants and the arctangent table for the quad vertex setup
package rqvs_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;

    localparam int SCALE_W     = 16;
    localparam int COORD_W     = 16;
    localparam int ANGLE_W     = 16;
    localparam int SHADER_W    = 32;
    localparam int OUT_W       = 20;
    localparam int CFG_INDEX_W = 8;
    localparam int SHIFT_W     = 5;
    localparam int CORNERS     = 4;

    // internal widths
    localparam int EXT_W     = 33;   // half extent, 2^-17 pixel
    localparam int CTR_W     = 35;   // centre, 2^-17 pixel
    localparam int TRIG_W    = 33;   // cordic x and y, Q2.30 with headroom
    localparam int ZW        = 33;   // residual angle, Q2.30 with headroom
    localparam int ANG_W     = 18;   // angle while it is being wrapped
    localparam int ANG_RED_W = 14;   // angle within one quarter turn
    localparam int ZPROD_W   = 50;
    localparam int PROD_W    = EXT_W + TRIG_W;
    localparam int TERM_W    = 36;
    localparam int SUM_W     = 38;

    localparam logic signed [ANG_W-1:0] FULL_TURN    = 18'sd23040;
    localparam logic signed [ANG_W-1:0] HALF_TURN    = 18'sd11520;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 18'sd5760;

    // degrees/64 to radians Q2.30, scaled by 2^16
    localparam logic signed [35:0] RAD_K = 36'sd19190098069;
    localparam logic signed [TRIG_W-1:0] CORDIC_INIT = 33'sd652032874;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd4096;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_X_SCALE = 8'd0,
        REG_Y_SCALE = 8'd1
    } rqvs_reg_t;

    // cordic vector and residual angle
    typedef struct packed {
        logic signed [TRIG_W-1:0] x;
        logic signed [TRIG_W-1:0] y;
        logic signed [ZW-1:0]     z;
    } rqvs_rot_t;

    // per-sprite data riding alongside the cordic
    typedef struct packed {
        logic signed [EXT_W-1:0] hw;
        logic signed [EXT_W-1:0] hh;
        logic signed [CTR_W-1:0] cx;
        logic signed [CTR_W-1:0] cy;
        logic                    neg;
        logic [SHADER_W-1:0]     shader;
    } rqvs_carry_t;

    // atan(2^-i) in Q2.30, truncated
    function automatic logic signed [ZW-1:0] atan_q30(input logic [SHIFT_W-1:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = 33'sd843314856;
            5'd1:    v = 33'sd497837829;
            5'd2:    v = 33'sd263043836;
            5'd3:    v = 33'sd133525158;
            5'd4:    v = 33'sd67021686;
            5'd5:    v = 33'sd33543515;
            5'd6:    v = 33'sd16775850;
            5'd7:    v = 33'sd8388437;
            5'd8:    v = 33'sd4194282;
            5'd9:    v = 33'sd2097149;
            5'd10:   v = 33'sd1048575;
            5'd11:   v = 33'sd524287;
            5'd12:   v = 33'sd262143;
            5'd13:   v = 33'sd131071;
            5'd14:   v = 33'sd65535;
            5'd15:   v = 33'sd32767;
            5'd16:   v = 33'sd16383;
            5'd17:   v = 33'sd8191;
            5'd18:   v = 33'sd4095;
            5'd19:   v = 33'sd2047;
            5'd20:   v = 33'sd1023;
            5'd21:   v = 33'sd511;
            5'd22:   v = 33'sd255;
            5'd23:   v = 33'sd127;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/rqvs_front.sv]
// front end: scaling, angle wrap, conversion to radians and cordic seed
module rqvs_front
    import rqvs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] left,
    input  logic signed [COORD_W-1:0] top,
    input  logic signed [COORD_W-1:0] width,
    input  logic signed [COORD_W-1:0] height,
    input  logic signed [ANGLE_W-1:0] angle_deg,
    input  logic [SHADER_W-1:0]       shader_in,
    input  logic [SCALE_W-1:0]        x_scale,
    input  logic [SCALE_W-1:0]        y_scale,
    output logic                      out_valid,
    input  logic                      out_ready,
    output rqvs_rot_t                 out_rot,
    output rqvs_carry_t               out_carry
);

    logic                        s0_valid_reg;
    logic signed [ANG_RED_W-1:0] s0_angle_reg;
    rqvs_carry_t                 s0_carry_reg;
    rqvs_carry_t                 s0_carry_next;
    logic                        s1_valid_reg;
    rqvs_rot_t                   s1_rot_reg;
    rqvs_rot_t                   s1_rot_next;
    rqvs_carry_t                 s1_carry_reg;

    logic signed [SCALE_W:0]     xs;
    logic signed [SCALE_W:0]     ys;
    logic signed [EXT_W-1:0]     lx;
    logic signed [EXT_W-1:0]     ty;
    logic signed [EXT_W-1:0]     hw;
    logic signed [EXT_W-1:0]     hh;
    logic signed [ANG_W-1:0]     ang;
    logic signed [ANG_W-1:0]     a_full;
    logic signed [ANG_W-1:0]     a_half;
    logic signed [ANG_W-1:0]     a_quad;
    logic                        neg;
    logic signed [ZPROD_W-1:0]   z_prod;
    logic                        s0_ready;
    logic                        s1_ready;

    assign s1_ready = !s1_valid_reg || out_ready;
    assign s0_ready = !s0_valid_reg || s1_ready;
    assign in_ready = s0_ready;

    // scaled half extents in 2^-17 pixel and top-left corner in 2^-16 pixel
    assign xs = {1'b0, x_scale};
    assign ys = {1'b0, y_scale};
    assign lx = left * xs;
    assign ty = top * ys;
    assign hw = width * xs;
    assign hh = height * ys;

    // wrap to one turn, then fold into a quarter turn
    always_comb
    begin
        ang = ANG_W'(angle_deg);
        if (ang < -FULL_TURN)
            a_full = ang + FULL_TURN + FULL_TURN;
        else if (ang < 0)
            a_full = ang + FULL_TURN;
        else if (ang >= FULL_TURN)
            a_full = ang - FULL_TURN;
        else
            a_full = ang;
        a_half = (a_full > HALF_TURN) ? a_full - FULL_TURN : a_full;
        if (a_half > QUARTER_TURN)
        begin
            a_quad = a_half - HALF_TURN;
            neg    = 1'b1;
        end
        else if (a_half < -QUARTER_TURN)
        begin
            a_quad = a_half + HALF_TURN;
            neg    = 1'b1;
        end
        else
        begin
            a_quad = a_half;
            neg    = 1'b0;
        end
    end

    always_comb
    begin
        s0_carry_next.hw     = hw;
        s0_carry_next.hh     = hh;
        s0_carry_next.cx     = (CTR_W'(lx) <<< 1) + CTR_W'(hw);
        s0_carry_next.cy     = (CTR_W'(ty) <<< 1) + CTR_W'(hh);
        s0_carry_next.neg    = neg;
        s0_carry_next.shader = shader_in;
    end

    // radians Q2.30, rounded
    assign z_prod = ZPROD_W'(s0_angle_reg) * ZPROD_W'(RAD_K) + ZPROD_W'(32768);

    always_comb
    begin
        s1_rot_next.x = CORDIC_INIT;
        s1_rot_next.y = '0;
        s1_rot_next.z = z_prod[ZW+15:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (s0_ready)
                s0_valid_reg <= in_valid;
            if (s1_ready)
                s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s0_ready)
        begin
            s0_angle_reg <= a_quad[ANG_RED_W-1:0];
            s0_carry_reg <= s0_carry_next;
        end
        if (s0_valid_reg && s1_ready)
        begin
            s1_rot_reg   <= s1_rot_next;
            s1_carry_reg <= s0_carry_reg;
        end
    end

    assign out_valid = s1_valid_reg;
    assign out_rot   = s1_rot_reg;
    assign out_carry = s1_carry_reg;

    a_angle_folded: assert property (@(posedge clk) disable iff (!rst_n)
        s0_valid_reg |-> (ANG_W'(s0_angle_reg) <= QUARTER_TURN)
                      && (ANG_W'(s0_angle_reg) >= -QUARTER_TURN))
        else $error("folded angle outside a quarter turn");

endmodule

[rtl/rqvs_cordic_cell.sv]
// one cordic rotation step with its own pipeline register
module rqvs_cordic_cell
    import rqvs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [SHIFT_W-1:0]   shift,
    input  logic signed [ZW-1:0] atan,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rqvs_rot_t            in_rot,
    input  rqvs_carry_t          in_carry,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rqvs_rot_t            out_rot,
    output rqvs_carry_t          out_carry
);

    logic                     valid_reg;
    rqvs_rot_t                rot_reg;
    rqvs_rot_t                rot_next;
    rqvs_carry_t              carry_reg;
    logic signed [TRIG_W-1:0] xi;
    logic signed [TRIG_W-1:0] yi;
    logic signed [ZW-1:0]     zi;
    logic signed [TRIG_W-1:0] dx;
    logic signed [TRIG_W-1:0] dy;

    assign in_ready = !valid_reg || out_ready;

    assign xi = in_rot.x;
    assign yi = in_rot.y;
    assign zi = in_rot.z;
    assign dx = yi >>> shift;
    assign dy = xi >>> shift;

    // zero residual rotates the positive way
    always_comb
    begin
        if (!zi[ZW-1])
        begin
            rot_next.x = xi - dx;
            rot_next.y = yi + dy;
            rot_next.z = zi - atan;
        end
        else
        begin
            rot_next.x = xi + dx;
            rot_next.y = yi - dy;
            rot_next.z = zi + atan;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            rot_reg   <= rot_next;
            carry_reg <= in_carry;
        end
    end

    assign out_valid = valid_reg;
    assign out_rot   = rot_reg;
    assign out_carry = carry_reg;

endmodule

[rtl/rqvs_corner.sv]
// corner assembly: trig products, rounding, corner sums and saturation
module rqvs_corner
    import rqvs_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  rqvs_rot_t                    in_rot,
    input  rqvs_carry_t                  in_carry,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [2*CORNERS-1:0][OUT_W-1:0] coords,
    output logic [SHADER_W-1:0]          shader_out
);

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(524287);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(524288);

    // multiply stage
    logic                     m_valid_reg;
    logic signed [PROD_W-1:0] m_cw_reg;
    logic signed [PROD_W-1:0] m_sw_reg;
    logic signed [PROD_W-1:0] m_ch_reg;
    logic signed [PROD_W-1:0] m_sh_reg;
    rqvs_carry_t              m_carry_reg;
    // rounding stage
    logic                     r_valid_reg;
    logic signed [TERM_W-1:0] r_cw_reg;
    logic signed [TERM_W-1:0] r_sw_reg;
    logic signed [TERM_W-1:0] r_ch_reg;
    logic signed [TERM_W-1:0] r_sh_reg;
    rqvs_carry_t              r_carry_reg;
    // output register
    logic                     o_valid_reg;
    logic [2*CORNERS-1:0][OUT_W-1:0] o_coord_reg;
    logic [2*CORNERS-1:0][OUT_W-1:0] o_coord_next;
    logic [SHADER_W-1:0]      o_shader_reg;

    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [EXT_W-1:0]  hw;
    logic signed [EXT_W-1:0]  hh;
    logic signed [CTR_W-1:0]  cx;
    logic signed [CTR_W-1:0]  cy;
    logic signed [PROD_W-1:0] rnd;
    logic signed [SUM_W-1:0]  cxe;
    logic signed [SUM_W-1:0]  cye;
    logic signed [SUM_W-1:0]  cw;
    logic signed [SUM_W-1:0]  sw;
    logic signed [SUM_W-1:0]  ch;
    logic signed [SUM_W-1:0]  sh;
    logic                     o_ready;
    logic                     r_ready;
    logic                     m_ready;

    function automatic logic [OUT_W-1:0] round_sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        r = (v + SUM_W'(4096)) >>> 13;
        if (r > SAT_MAX)
            r = SAT_MAX;
        else if (r < SAT_MIN)
            r = SAT_MIN;
        return r[OUT_W-1:0];
    endfunction

    assign o_ready  = !o_valid_reg || !out_stall;
    assign r_ready  = !r_valid_reg || o_ready;
    assign m_ready  = !m_valid_reg || r_ready;
    assign in_ready = m_ready;

    // quadrant fold flips both cos and sin
    assign cos_v = in_carry.neg ? -in_rot.x : in_rot.x;
    assign sin_v = in_carry.neg ? -in_rot.y : in_rot.y;
    assign hw    = in_carry.hw;
    assign hh    = in_carry.hh;
    assign rnd   = PROD_W'(1) <<< 29;

    assign cx  = r_carry_reg.cx;
    assign cy  = r_carry_reg.cy;
    assign cxe = SUM_W'(cx);
    assign cye = SUM_W'(cy);
    assign cw  = SUM_W'(r_cw_reg);
    assign sw  = SUM_W'(r_sw_reg);
    assign ch  = SUM_W'(r_ch_reg);
    assign sh  = SUM_W'(r_sh_reg);

    always_comb
    begin
        o_coord_next[0] = round_sat(cxe - cw + sw);
        o_coord_next[1] = round_sat(cye - sh - ch);
        o_coord_next[2] = round_sat(cxe + cw + sw);
        o_coord_next[3] = round_sat(cye + sh - ch);
        o_coord_next[4] = round_sat(cxe + cw - sw);
        o_coord_next[5] = round_sat(cye + sh + ch);
        o_coord_next[6] = round_sat(cxe - cw - sw);
        o_coord_next[7] = round_sat(cye - sh + ch);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_ready)
                m_valid_reg <= in_valid;
            if (r_ready)
                r_valid_reg <= m_valid_reg;
            if (o_ready)
                o_valid_reg <= r_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && m_ready)
        begin
            m_cw_reg    <= PROD_W'(hw) * PROD_W'(cos_v);
            m_sw_reg    <= PROD_W'(hw) * PROD_W'(sin_v);
            m_ch_reg    <= PROD_W'(hh) * PROD_W'(cos_v);
            m_sh_reg    <= PROD_W'(hh) * PROD_W'(sin_v);
            m_carry_reg <= in_carry;
        end
        if (m_valid_reg && r_ready)
        begin
            // floor((p + 2^29) / 2^30)
            r_cw_reg    <= TERM_W'((m_cw_reg + rnd) >>> 30);
            r_sw_reg    <= TERM_W'((m_sw_reg + rnd) >>> 30);
            r_ch_reg    <= TERM_W'((m_ch_reg + rnd) >>> 30);
            r_sh_reg    <= TERM_W'((m_sh_reg + rnd) >>> 30);
            r_carry_reg <= m_carry_reg;
        end
        if (r_valid_reg && o_ready)
        begin
            o_coord_reg  <= o_coord_next;
            o_shader_reg <= r_carry_reg.shader;
        end
    end

    assign out_valid  = o_valid_reg;
    assign coords     = o_coord_reg;
    assign shader_out = o_shader_reg;

    a_out_from_round: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(o_valid_reg) |-> $past(r_valid_reg))
        else $error("result appeared without a rounded item behind it");

    a_round_holds: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid_reg && !o_ready |=> r_valid_reg && $stable(r_cw_reg) && $stable(r_sh_reg))
        else $error("rounding stage lost its item while blocked");

endmodule

[rtl/rotated_quad_vertex_setup.sv]
// top level of the rotated sprite quad vertex setup pipeline
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-------------------------------------
//   input   | in        | in_valid / in_stall      | left top width height angle_deg shader_in
//   output  | out       | out_valid / out_stall    | v0_x .. v3_y shader_out
//   config  | in        | cfg_valid / cfg_ready    | cfg_index cfg_data
//
// one transaction per clock in and out while out_stall is low; the registers in order are
// two front stages, one cordic cell per iteration, multiply, round, output register
// reset clears every stage valid and loads both scales with 1.0 (4096)
// a stall only backs up through stages that hold a transaction, so empty
// slots are squeezed out and input keeps flowing while the output waits, until every slot is full
// config writes are always taken and land in the next cycle
module rotated_quad_vertex_setup
    import rqvs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [SCALE_W-1:0]        cfg_data,
    // sprite input
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [COORD_W-1:0] left,
    input  logic signed [COORD_W-1:0] top,
    input  logic signed [COORD_W-1:0] width,
    input  logic signed [COORD_W-1:0] height,
    input  logic signed [ANGLE_W-1:0] angle_deg,
    input  logic [SHADER_W-1:0]       shader_in,
    // quad output
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [OUT_W-1:0]   v0_x,
    output logic signed [OUT_W-1:0]   v0_y,
    output logic signed [OUT_W-1:0]   v1_x,
    output logic signed [OUT_W-1:0]   v1_y,
    output logic signed [OUT_W-1:0]   v2_x,
    output logic signed [OUT_W-1:0]   v2_y,
    output logic signed [OUT_W-1:0]   v3_x,
    output logic signed [OUT_W-1:0]   v3_y,
    output logic [SHADER_W-1:0]       shader_out
);

    logic [SCALE_W-1:0] x_scale_reg;
    logic [SCALE_W-1:0] y_scale_reg;

    // chain position 0 is the front end output, k is the output of cell k-1
    logic [CORDIC_STAGES:0] chain_valid;
    logic [CORDIC_STAGES:0] chain_ready;
    rqvs_rot_t              chain_rot   [CORDIC_STAGES+1];
    rqvs_carry_t            chain_carry [CORDIC_STAGES+1];

    logic                   front_ready;
    logic [2*CORNERS-1:0][OUT_W-1:0] coords;

    // scale registers, writes to unknown indexes fall through
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_scale_reg <= SCALE_RESET;
            y_scale_reg <= SCALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_X_SCALE: x_scale_reg <= cfg_data;
                REG_Y_SCALE: y_scale_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    assign in_stall = !front_ready;

    // scaling, angle fold and radian conversion
    rqvs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (front_ready),
        .left      (left),
        .top       (top),
        .width     (width),
        .height    (height),
        .angle_deg (angle_deg),
        .shader_in (shader_in),
        .x_scale   (x_scale_reg),
        .y_scale   (y_scale_reg),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_rot   (chain_rot[0]),
        .out_carry (chain_carry[0])
    );

    // one cell per cordic iteration, each with a fixed shift and angle step
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        rqvs_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (SHIFT_W'(i)),
            .atan      (atan_q30(SHIFT_W'(i))),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_rot    (chain_rot[i]),
            .in_carry  (chain_carry[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_rot   (chain_rot[i+1]),
            .out_carry (chain_carry[i+1])
        );
    end

    // products with the half extents and the four corner sums
    rqvs_corner u_corner (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (chain_valid[CORDIC_STAGES]),
        .in_ready   (chain_ready[CORDIC_STAGES]),
        .in_rot     (chain_rot[CORDIC_STAGES]),
        .in_carry   (chain_carry[CORDIC_STAGES]),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .coords     (coords),
        .shader_out (shader_out)
    );

    assign v0_x = coords[0];
    assign v0_y = coords[1];
    assign v1_x = coords[2];
    assign v1_y = coords[3];
    assign v2_x = coords[4];
    assign v2_y = coords[5];
    assign v3_x = coords[6];
    assign v3_y = coords[7];

    // input only backs up once every slot down to the output is occupied
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall && (&chain_valid))
        else $error("input stalled with a free slot in the pipeline");

    a_x_scale_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && (cfg_index == REG_X_SCALE)
        |=> x_scale_reg == $past(cfg_data))
        else $error("horizontal scale write not taken");

    a_y_scale_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && (cfg_index == REG_Y_SCALE)
        |=> y_scale_reg == $past(cfg_data))
        else $error("vertical scale write not taken");

endmodule

[tb/rqvs_quad_checker.sv]
// scoreboard for the quad vertex setup: predicts the four corners of each sprite and compares
module rqvs_quad_checker
    import rqvs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [SCALE_W-1:0]        cfg_data,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic signed [COORD_W-1:0] left,
    input  logic signed [COORD_W-1:0] top,
    input  logic signed [COORD_W-1:0] width,
    input  logic signed [COORD_W-1:0] height,
    input  logic signed [ANGLE_W-1:0] angle_deg,
    input  logic [SHADER_W-1:0]       shader_in,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic signed [OUT_W-1:0]   v0_x,
    input  logic signed [OUT_W-1:0]   v0_y,
    input  logic signed [OUT_W-1:0]   v1_x,
    input  logic signed [OUT_W-1:0]   v1_y,
    input  logic signed [OUT_W-1:0]   v2_x,
    input  logic signed [OUT_W-1:0]   v2_y,
    input  logic signed [OUT_W-1:0]   v3_x,
    input  logic signed [OUT_W-1:0]   v3_y,
    input  logic [SHADER_W-1:0]       shader_out,
    output int                        errors,
    output int                        pending
);

    localparam longint TURN_UNITS    = 23040;
    localparam longint HALF_UNITS    = 11520;
    localparam longint QUARTER_UNITS = 5760;
    localparam longint UNITS_TO_RAD  = 64'sd19190098069;
    localparam longint INV_GAIN_Q30  = 64'sd652032874;
    localparam longint PIXEL_MAX     = 524287;
    localparam longint PIXEL_MIN     = -524288;
    localparam int     ARCTAN_LEN    = 24;
    localparam int     ROTATIONS     = (CORDIC_STAGES < ARCTAN_LEN) ? CORDIC_STAGES : ARCTAN_LEN;
    localparam logic [SCALE_W-1:0] UNITY_Q12 = 16'd4096;

    // atan(2^-i), Q2.30, truncated
    localparam longint ARCTAN_Q30 [ARCTAN_LEN] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767, 16383, 8191,
        4095, 2047, 1023, 511, 255, 127
    };

    typedef struct packed {
        logic [2*CORNERS-1:0][OUT_W-1:0] coord;   // v0_x, v0_y, ... v3_y from index 0
        logic [SHADER_W-1:0]             shader;
    } quad_t;

    quad_t              expected_quads [$];
    logic [SCALE_W-1:0] x_scale;
    logic [SCALE_W-1:0] y_scale;
    int                 fail_tally = 0;

    // round 2^-17 pixel to Q16.4 and clamp
    function automatic logic [OUT_W-1:0] to_pixel(input longint v);
        longint r;
        r = (v + 64'sd4096) >>> 13;
        if (r > PIXEL_MAX)
            r = PIXEL_MAX;
        else if (r < PIXEL_MIN)
            r = PIXEL_MIN;
        return r[OUT_W-1:0];
    endfunction

    function automatic longint times_trig(input longint ext, input longint t);
        return (ext * t + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // sine and cosine in Q2.30 of an angle in 1/64 degree
    function automatic void unit_vector(input longint turn_units,
                                        output longint sin_q30, output longint cos_q30);
        longint a;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        logic   flip;
        int     i;
        a = turn_units % TURN_UNITS;
        if (a < 0)
            a += TURN_UNITS;
        if (a > HALF_UNITS)
            a -= TURN_UNITS;
        flip = 1'b0;
        if (a > QUARTER_UNITS)
        begin
            a -= HALF_UNITS;
            flip = 1'b1;
        end
        else if (a < -QUARTER_UNITS)
        begin
            a += HALF_UNITS;
            flip = 1'b1;
        end
        z = (a * UNITS_TO_RAD + (64'sd1 <<< 15)) >>> 16;
        x = INV_GAIN_Q30;
        y = 0;
        for (i = 0; i < ROTATIONS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= ARCTAN_Q30[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += ARCTAN_Q30[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        cos_q30 = x;
        sin_q30 = y;
    endfunction

    function automatic quad_t compute_corners(input logic signed [COORD_W-1:0] l,
                                              input logic signed [COORD_W-1:0] t,
                                              input logic signed [COORD_W-1:0] w,
                                              input logic signed [COORD_W-1:0] h,
                                              input logic signed [ANGLE_W-1:0] ang,
                                              input logic [SHADER_W-1:0] handle);
        longint hw;
        longint hh;
        longint cx;
        longint cy;
        longint s;
        longint c;
        longint cw;
        longint sw;
        longint ch;
        longint sh;
        quad_t  q;
        hw = longint'(w) * longint'(x_scale);
        hh = longint'(h) * longint'(y_scale);
        cx = 2 * longint'(l) * longint'(x_scale) + hw;
        cy = 2 * longint'(t) * longint'(y_scale) + hh;
        unit_vector(longint'(ang), s, c);
        cw = times_trig(hw, c);
        sw = times_trig(hw, s);
        ch = times_trig(hh, c);
        sh = times_trig(hh, s);
        q.coord[0] = to_pixel(cx - cw + sw);
        q.coord[1] = to_pixel(cy - sh - ch);
        q.coord[2] = to_pixel(cx + cw + sw);
        q.coord[3] = to_pixel(cy + sh - ch);
        q.coord[4] = to_pixel(cx + cw - sw);
        q.coord[5] = to_pixel(cy + sh + ch);
        q.coord[6] = to_pixel(cx - cw - sw);
        q.coord[7] = to_pixel(cy - sh + ch);
        q.shader   = handle;
        return q;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        quad_t got;
        quad_t want;
        int    k;
        if (!rst_n)
        begin
            x_scale <= UNITY_Q12;
            y_scale <= UNITY_Q12;
            expected_quads.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.coord  = {v3_y, v3_x, v2_y, v2_x, v1_y, v1_x, v0_y, v0_x};
                got.shader = shader_out;
                if (expected_quads.size() == 0)
                begin
                    $error("quad transaction with no sprite outstanding, shader_out %h",
                           shader_out);
                    fail_tally++;
                end
                else
                begin
                    want = expected_quads.pop_front();
                    for (k = 0; k < 2 * CORNERS; k++)
                    begin
                        if (got.coord[k] !== want.coord[k])
                        begin
                            $error("v%0d_%s: expected %0d, actual %0d", k / 2,
                                   (k % 2) ? "y" : "x",
                                   $signed(want.coord[k]), $signed(got.coord[k]));
                            fail_tally++;
                        end
                    end
                    if (got.shader !== want.shader)
                    begin
                        $error("shader_out: expected %h, actual %h", want.shader, got.shader);
                        fail_tally++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_quads.push_back(compute_corners(left, top, width, height,
                                                         angle_deg, shader_in));
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_X_SCALE)
                    x_scale <= cfg_data;
                else if (cfg_index == REG_Y_SCALE)
                    y_scale <= cfg_data;
            end
            errors  <= fail_tally;
            pending <= expected_quads.size();
        end
    end

endmodule

[tb/tb_top.sv]
// stimulus and verdict for the rotated quad vertex setup, with the scoreboard beside the block
module tb_top;
    import rqvs_pkg::*;

    // run length and pressure knobs
    localparam int CYCLE_LIMIT     = 300000;
    localparam int SEGMENTS        = 6;
    localparam int SEGMENT_ITEMS   = 200;
    localparam int HOLD_CYCLES     = 300;
    localparam int FIRST_SPARE_REG = int'(REG_Y_SCALE) + 1;
    localparam int LAST_REG_INDEX  = (1 << CFG_INDEX_W) - 1;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_W-1:0]    cfg_index;
    logic [SCALE_W-1:0]        cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] width;
    logic signed [COORD_W-1:0] height;
    logic signed [ANGLE_W-1:0] angle_deg;
    logic [SHADER_W-1:0]       shader_in;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [OUT_W-1:0]   v0_x;
    logic signed [OUT_W-1:0]   v0_y;
    logic signed [OUT_W-1:0]   v1_x;
    logic signed [OUT_W-1:0]   v1_y;
    logic signed [OUT_W-1:0]   v2_x;
    logic signed [OUT_W-1:0]   v2_y;
    logic signed [OUT_W-1:0]   v3_x;
    logic signed [OUT_W-1:0]   v3_y;
    logic [SHADER_W-1:0]       shader_out;

    int   mismatches;
    int   outstanding;
    int   cycle_count   = 0;
    int   sprites_taken = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_off;

    rotated_quad_vertex_setup DUT (.*);

    rqvs_quad_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .left       (left),
        .top        (top),
        .width      (width),
        .height     (height),
        .angle_deg  (angle_deg),
        .shader_in  (shader_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .v0_x       (v0_x),
        .v0_y       (v0_y),
        .v1_x       (v1_x),
        .v1_y       (v1_y),
        .v2_x       (v2_x),
        .v2_y       (v2_y),
        .v3_x       (v3_x),
        .v3_y       (v3_y),
        .shader_out (shader_out),
        .errors     (mismatches),
        .pending    (outstanding)
    );

    // 12 unit clock period
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop in case a transaction never shows up
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // receiver side: random stalls, or a solid hold-off while a long stall is running
    always @(posedge clk)
        out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);

    // long receiver hold-offs, counted here, while the sender keeps offering sprites;
    // the pipeline fills and the block must stall its input
    initial
    begin : long_hold
        int n;
        hold_off = 1'b0;
        for (n = 0; n < 2; n++)
        begin
            wait (sprites_taken >= ((n == 0) ? 300 : 1000));
            @(posedge clk);
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_off <= 1'b0;
        end
    end

    // one sprite transaction; valid stays up afterwards unless the next call idles first
    task automatic offer_sprite(input logic signed [COORD_W-1:0] l,
                                input logic signed [COORD_W-1:0] t,
                                input logic signed [COORD_W-1:0] w,
                                input logic signed [COORD_W-1:0] h,
                                input logic signed [ANGLE_W-1:0] ang,
                                input logic [SHADER_W-1:0] handle);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        left      <= l;
        top       <= t;
        width     <= w;
        height    <= h;
        angle_deg <= ang;
        shader_in <= handle;
        in_valid  <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sprites_taken++;
    endtask

    // register write; the caller drops cfg_valid after the last one
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [SCALE_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // drain the pipeline, then load both scales with a stray write to an unmapped index between
    task automatic load_scales(input logic [SCALE_W-1:0] xs, input logic [SCALE_W-1:0] ys);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        write_reg(REG_X_SCALE, xs);
        write_reg(CFG_INDEX_W'($urandom_range(LAST_REG_INDEX, FIRST_SPARE_REG)),
                  SCALE_W'($urandom));
        write_reg(REG_Y_SCALE, ys);
        cfg_valid <= 1'b0;
    endtask

    // coordinates: full range, near the rails, or ordinary screen positions
    function automatic logic [COORD_W-1:0] pick_coord();
        int v;
        case ($urandom_range(3))
            0:       v = $urandom_range(65535);
            1:       v = $urandom_range(1) ? 32'h7FFF - $urandom_range(3)
                                           : 32'h8000 + $urandom_range(3);
            default: v = int'($urandom_range(8192)) - 4096;
        endcase
        return v[COORD_W-1:0];
    endfunction

    // angles: full range, two turns, around thirty-second-turn steps, or small tilts
    function automatic logic [ANGLE_W-1:0] pick_angle();
        int v;
        case ($urandom_range(3))
            0:       v = $urandom_range(65535);
            1:       v = int'($urandom_range(46080)) - 23040;
            2:       v = (int'($urandom_range(64)) - 32) * 720 + int'($urandom_range(2)) - 1;
            default: v = int'($urandom_range(1440)) - 720;
        endcase
        return v[ANGLE_W-1:0];
    endfunction

    initial
    begin : stimulus
        int seg;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        left      = '0;
        top       = '0;
        width     = '0;
        height    = '0;
        angle_deg = '0;
        shader_in = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed, scales at their reset value of 1.0
        offer_sprite(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0000_0000);
        offer_sprite(16'sd1600, 16'sd800, 16'sd1024, 16'sd512, 16'sd0, 32'h0000_0001);
        offer_sprite(16'sd1600, 16'sd800, 16'sd1024, 16'sd512, 16'sd5760, 32'h0000_0002);
        offer_sprite(16'sd1600, 16'sd800, 16'sd1024, 16'sd512, -16'sd5760, 32'h0000_0003);
        // just past a quarter turn either way, and a half turn, folded back by a half turn
        offer_sprite(16'sd1600, 16'sd800, 16'sd1024, 16'sd512, 16'sd5761, 32'h0000_0004);
        offer_sprite(16'sd1600, 16'sd800, 16'sd1024, 16'sd512, -16'sd5761, 32'h0000_0005);
        offer_sprite(16'sd1600, 16'sd800, 16'sd1024, 16'sd512, 16'sd11520, 32'h0000_0006);
        // angles of one turn and beyond wrap
        offer_sprite(16'sd1600, 16'sd800, 16'sd1024, 16'sd512, 16'sd23040, 32'h0000_0007);
        offer_sprite(16'sd1600, 16'sd800, 16'sd1024, 16'sd512, 16'sh7FFF, 32'h0000_0008);
        offer_sprite(16'sd1600, 16'sd800, 16'sd1024, 16'sd512, 16'sh8000, 32'h0000_0009);
        // negative size mirrors the quad
        offer_sprite(16'sd3200, 16'sd3200, -16'sd640, -16'sd320, 16'sd2880, 32'h0000_000A);
        offer_sprite(16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 32'hFFFF_FFFF);

        // largest scales, the big sprites hit the saturation rails
        load_scales(16'hFFFF, 16'hFFFF);
        offer_sprite(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sd0, 32'h8000_0000);
        offer_sprite(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sd0, 32'h7FFF_FFFF);
        offer_sprite(16'sh7FFF, 16'sd0, 16'sh8000, 16'sd0, 16'sd11520, 32'h1234_5678);
        offer_sprite(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sd2880, 32'hDEAD_0001);
        offer_sprite(16'sh5555, 16'shAAAA, 16'sh2AAA, 16'shD555, 16'sh1555, 32'hA5A5_5A5A);
        offer_sprite(16'sd160, 16'sd160, 16'sd320, 16'sd160, -16'sd23040, 32'h0000_0010);
        offer_sprite(16'sd160, 16'sd160, 16'sd320, 16'sd160, 16'sd17280, 32'h0000_0011);
        offer_sprite(16'sd160, 16'sd160, 16'sd320, 16'sd160, -16'sd17280, 32'h0000_0012);

        // random segments: sender mostly busy first, then receiver, then no idling at all
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg)
                0:       load_scales(SCALE_W'($urandom_range(8192, 2048)),
                                     SCALE_W'($urandom_range(8192, 2048)));
                1:       load_scales(16'h0000, 16'hFFFF);
                2:       load_scales(16'hFFFF, 16'h0000);
                3:       load_scales(SCALE_W'($urandom), SCALE_W'($urandom));
                4:       load_scales(SCALE_W'($urandom_range(16384, 1024)),
                                     SCALE_W'($urandom_range(16384, 1024)));
                default: load_scales(16'd4096, SCALE_W'($urandom_range(65535, 32768)));
            endcase
            send_idle_pct = (seg < 2) ? 14 : (seg < 4) ? 61 : 0;
            recv_idle_pct = (seg < 2) ? 61 : (seg < 4) ? 14 : 0;
            repeat (SEGMENT_ITEMS)
                offer_sprite(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                             pick_angle(), $urandom());
        end

        // drain, then give the pipeline time to show any stray transaction
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (CORDIC_STAGES + 8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

[rotated_quad_vertex_setup.f]
rtl/rqvs_pkg.sv
rtl/rqvs_front.sv
rtl/rqvs_cordic_cell.sv
rtl/rqvs_corner.sv
rtl/rotated_quad_vertex_setup.sv
tb/rqvs_quad_checker.sv
tb/tb_top.sv
